/* hdl/assert_macros.svh */
// Assertion helpers; clk and arst_n must be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is active
`define ASSERT_IMP(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is active
`define ASSERT_NXT(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("assertion failed");

`endif

/* hdl/alp_pkg.sv */
package alp_pkg;

	localparam int FIELD_W = 24;

	localparam logic [31:0] ONE_Q22    = 32'h0040_0000;
	localparam logic [23:0] ENV_MAX    = 24'hFF_FFFF;
	localparam logic [23:0] ENV_FLOOR  = 24'd4194;
	localparam logic [23:0] GAIN_ONE   = 24'd1048576;
	localparam logic [23:0] GAIN_FLOOR = 24'd209715;
	localparam logic [14:0] SMOOTH_Q24 = 15'd16777;

	// mode register bits
	localparam int MODE_FILT = 0;
	localparam int MODE_AGC  = 1;
	localparam int MODE_LIM  = 2;
	localparam int MODE_MONO = 3;

	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_TARGET  = 3'd1,
		REG_ATTACK  = 3'd2,
		REG_RELEASE = 3'd3,
		REG_MAXGAIN = 3'd4,
		REG_COEF0   = 3'd5,
		REG_COEF1   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic filt;
		logic gain;
		logic clip;
	} lane_cmd_t;

	typedef struct packed {
		logic busy;
	} lane_sts_t;

	// Clamp a signed value to a signed range of the given width
	function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
		input int unsigned bits);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

endpackage

/* hdl/alp_div.sv */
// Restoring divider, one quotient bit per cycle; quotient must fit QUO_W bits
module alp_div #(
	parameter int NUM_W = 43,
	parameter int DEN_W = 24,
	parameter int QUO_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [QUO_W-1:0] quo
);

	localparam int W     = DEN_W + QUO_W;
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;

	// Load operands, then subtract the shifted divisor where it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUO_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= W'(num);
			dsh_q <= W'(den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;

endmodule

/* hdl/alp_lane.sv */
// One channel: biquad cascade and gain multiply on a shared multiplier, soft limiter on a divider
module alp_lane #(
	parameter int SECTIONS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  alp_pkg::lane_cmd_t       cmd,
	input  logic signed [23:0]       sample,
	input  logic [23:0]              gain,
	input  logic [SECTIONS-1:0][62:0] coef,
	output alp_pkg::lane_sts_t       sts,
	output logic signed [31:0]       value
);

	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_FILT = 5'b00010,
		L_GMUL = 5'b00100,
		L_GRND = 5'b01000,
		L_CLIP = 5'b10000
	} lstate_t;

	lstate_t state_q;
	logic [SEC_W-1:0] sec_q;
	logic [2:0] ph_q;
	logic signed [31:0] x_q;
	logic signed [31:0] x1_q [SECTIONS];
	logic signed [31:0] x2_q [SECTIONS];
	logic signed [31:0] y1_q [SECTIONS];
	logic signed [31:0] y2_q [SECTIONS];
	logic signed [59:0] acc_q;
	logic signed [58:0] prod_s1;
	logic neg_q;

	logic [62:0] cur;
	logic signed [20:0] b1, a1, a2;
	logic signed [33:0] xs;
	logic signed [24:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [58:0] product;
	logic signed [59:0] acc_r;
	logic signed [59:0] rnd;
	logic signed [31:0] y;
	logic signed [58:0] grnd;
	logic [32:0] abs_x;
	logic [32:0] d;
	logic [36:0] ten_a;
	logic clip_go;
	logic div_busy;
	logic [19:0] quo;
	logic [31:0] mag;

	// Coefficients and tap sum of the current section
	assign cur = coef[sec_q];
	assign b1  = cur[20:0];
	assign a1  = cur[41:21];
	assign a2  = cur[62:42];
	assign xs  = 34'(x_q) + {x1_q[sec_q][31], x1_q[sec_q], 1'b0} + 34'(x2_q[sec_q]);

	// Select multiplier operands
	always_comb begin
		mul_a = $signed({1'b0, gain});
		mul_b = 34'(x_q);
		if (state_q == L_FILT) begin
			unique case (ph_q)
				3'd0: begin
					mul_a = 25'(b1);
					mul_b = xs;
				end
				3'd1: begin
					mul_a = 25'(a1);
					mul_b = 34'(y1_q[sec_q]);
				end
				default: begin
					mul_a = 25'(a2);
					mul_b = 34'(y2_q[sec_q]);
				end
			endcase
		end
	end

	assign product = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_s1 <= product;
	end

	// Round the accumulator to 22 fraction bits, saturate to 32 bits
	assign acc_r = acc_q + 60'sd524288;
	assign rnd   = acc_r >>> 20;
	assign y     = 32'(alp_pkg::sat_to(64'(rnd), 32));
	assign grnd  = (prod_s1 + 59'sd524288) >>> 20;

	// Limiter operands: d = |x| - 1, numerator 2*d*2^22 + 10*|x|, divisor 20*|x|
	assign abs_x   = x_q[31] ? (33'd0 - {x_q[31], x_q}) : {1'b0, x_q};
	assign d       = abs_x - {1'b0, alp_pkg::ONE_Q22};
	assign ten_a   = 37'({abs_x, 3'b000}) + 37'({abs_x, 1'b0});
	assign clip_go = (state_q == L_IDLE) && cmd.clip && !cmd.load
		&& (abs_x > {1'b0, alp_pkg::ONE_Q22});
	assign mag     = alp_pkg::ONE_Q22 + 32'(quo);

	alp_div #(
		.NUM_W(56),
		.DEN_W(37),
		.QUO_W(20)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (clip_go),
		.num   ({d, 23'b0} + 56'(ten_a)),
		.den   (37'({ten_a, 1'b0})),
		.busy  (div_busy),
		.quo   (quo)
	);

	// Sequence the lane work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			sec_q   <= '0;
			ph_q    <= '0;
			x_q     <= '0;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			for (int i = 0; i < SECTIONS; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				L_IDLE: begin
					priority if (cmd.load) begin
						x_q <= 32'(alp_pkg::sat_to(64'(sample), SAMPLE_BITS));
					end else if (cmd.filt) begin
						state_q <= L_FILT;
						sec_q   <= '0;
						ph_q    <= '0;
					end else if (cmd.gain) begin
						state_q <= L_GMUL;
					end else if (clip_go) begin
						neg_q   <= x_q[31];
						state_q <= L_CLIP;
					end
				end
				L_FILT: begin
					unique case (ph_q)
						3'd0: ph_q <= ph_q + 3'd1;
						3'd1: begin
							acc_q <= 60'(prod_s1);
							ph_q  <= ph_q + 3'd1;
						end
						3'd2, 3'd3: begin
							acc_q <= acc_q - {prod_s1, 1'b0};
							ph_q  <= ph_q + 3'd1;
						end
						default: begin
							x2_q[sec_q] <= x1_q[sec_q];
							x1_q[sec_q] <= x_q;
							y2_q[sec_q] <= y1_q[sec_q];
							y1_q[sec_q] <= y;
							ph_q <= '0;
							if (sec_q == SEC_W'(SECTIONS - 1)) begin
								x_q     <= 32'(alp_pkg::sat_to(64'(y), SAMPLE_BITS));
								state_q <= L_IDLE;
							end else begin
								x_q   <= y;
								sec_q <= sec_q + SEC_W'(1);
							end
						end
					endcase
				end
				L_GMUL: state_q <= L_GRND;
				L_GRND: begin
					x_q     <= 32'(alp_pkg::sat_to(64'(grnd), SAMPLE_BITS));
					state_q <= L_IDLE;
				end
				L_CLIP: begin
					if (!div_busy) begin
						x_q     <= neg_q ? -mag : mag;
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != L_IDLE);
	assign value    = x_q;

endmodule

/* hdl/audio_lpf_agc_limiter_top.sv */
// Stereo audio conditioner: per-channel lowpass biquad cascade, peak-envelope
// AGC and soft limiter, samples signed with 22 fraction bits. Two channel lanes
// run side by side; a merging stage takes the larger magnitude, updates the
// envelope and the smoothed gain, and the lanes then apply gain and limiting.
// One frame is processed at a time. The AGC divider runs when AGC is on and the
// envelope is above its floor, and the limiter divider runs when a sample
// exceeds one. The input is ready again once the frame moves to the output
// register, where it waits while the next frame is processed; a full output
// register holds the sequencer before that move.
`include "assert_macros.svh"

module audio_lpf_agc_limiter_top #(
	parameter int SECTIONS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // left_in [23:0], right_in [47:24]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // left_out [23:0], right_out [47:24]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [62:0] cfg_wdata
);

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_FILT   = 15'b000000000000010,
		S_FWAIT  = 15'b000000000000100,
		S_PEAK   = 15'b000000000001000,
		S_EMUL   = 15'b000000000010000,
		S_EUPD   = 15'b000000000100000,
		S_DIV    = 15'b000000001000000,
		S_DWAIT  = 15'b000000010000000,
		S_GMUL   = 15'b000000100000000,
		S_GUPD   = 15'b000001000000000,
		S_LGAIN  = 15'b000010000000000,
		S_LGWAIT = 15'b000100000000000,
		S_CLIP   = 15'b001000000000000,
		S_CWAIT  = 15'b010000000000000,
		S_DONE   = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic [3:0]  mode_q;
	logic [22:0] target_q;
	logic [24:0] attack_q;
	logic [24:0] release_q;
	logic [19:0] maxgain_q;
	logic [62:0] coef0_q;
	logic [62:0] coef1_q;
	logic [SECTIONS-1:0][62:0] coef_arr;

	logic [23:0] peak_q;
	logic [23:0] env_q;
	logic [23:0] gain_q;
	logic [23:0] desired_q;
	logic signed [50:0] prod_q;
	logic last_q;

	logic out_valid_q;
	logic [23:0] out_left_q;
	logic [23:0] out_right_q;
	logic out_last_q;

	alp_pkg::lane_cmd_t  lane_cmd [2];
	alp_pkg::lane_sts_t  lane_sts [2];
	logic signed [31:0]  lane_val [2];
	logic signed [23:0]  lane_smp [2];

	logic accept;
	logic mono;
	logic lanes_busy;
	logic out_load;
	logic [32:0] abs0, abs1, pk;
	logic [24:0] rate_sel;
	logic signed [25:0] tm_a;
	logic signed [24:0] tm_b;
	logic signed [50:0] tm_prod;
	logic signed [50:0] upd_rnd;
	logic signed [31:0] upd_sum;
	logic [23:0] upd_base;
	logic [23:0] upd_val;
	logic div_go;
	logic div_busy;
	logic [31:0] quo;
	logic [31:0] mg, qmin, qclamp;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 4'd7;
			target_q  <= 23'd3774874;
			attack_q  <= 25'd83886;
			release_q <= 25'd3355;
			maxgain_q <= 20'd131072;
			coef0_q   <= '0;
			coef1_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				alp_pkg::REG_MODE:    mode_q    <= cfg_wdata[3:0];
				alp_pkg::REG_TARGET:  target_q  <= cfg_wdata[22:0];
				alp_pkg::REG_ATTACK:  attack_q  <= cfg_wdata[24:0];
				alp_pkg::REG_RELEASE: release_q <= cfg_wdata[24:0];
				alp_pkg::REG_MAXGAIN: maxgain_q <= cfg_wdata[19:0];
				alp_pkg::REG_COEF0:   coef0_q   <= cfg_wdata;
				alp_pkg::REG_COEF1:   coef1_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	for (genvar s = 0; s < SECTIONS; s++) begin : g_coef
		assign coef_arr[s] = (s == 0) ? coef0_q : coef1_q;
	end

	assign mono          = mode_q[alp_pkg::MODE_MONO];
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign lanes_busy    = lane_sts[0].busy || lane_sts[1].busy;
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	// Lane commands
	assign lane_smp[0] = s_axis_tdata[23:0];
	assign lane_smp[1] = mono ? 24'sd0 : s_axis_tdata[47:24];

	for (genvar c = 0; c < 2; c++) begin : g_lane
		assign lane_cmd[c].load = accept;
		assign lane_cmd[c].filt = (state_q == S_FILT) && mode_q[alp_pkg::MODE_FILT]
			&& ((c == 0) || !mono);
		assign lane_cmd[c].gain = (state_q == S_LGAIN);
		assign lane_cmd[c].clip = (state_q == S_CLIP) && mode_q[alp_pkg::MODE_LIM];

		alp_lane #(
			.SECTIONS   (SECTIONS),
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (lane_cmd[c]),
			.sample(lane_smp[c]),
			.gain  (gain_q),
			.coef  (coef_arr),
			.sts   (lane_sts[c]),
			.value (lane_val[c])
		);
	end

	// Merge: larger magnitude of both lanes, saturated to 24 bits
	assign abs0 = lane_val[0][31] ? (33'd0 - {lane_val[0][31], lane_val[0]})
		: {1'b0, lane_val[0]};
	assign abs1 = lane_val[1][31] ? (33'd0 - {lane_val[1][31], lane_val[1]})
		: {1'b0, lane_val[1]};
	assign pk   = (abs1 > abs0) ? abs1 : abs0;

	// Shared multiplier for envelope and gain smoothing
	assign rate_sel = (peak_q > env_q) ? attack_q : release_q;

	always_comb begin
		if (state_q == S_GMUL) begin
			tm_a = 26'(signed'({1'b0, alp_pkg::SMOOTH_Q24}));
			tm_b = signed'({1'b0, desired_q}) - signed'({1'b0, gain_q});
		end else begin
			tm_a = signed'({1'b0, rate_sel});
			tm_b = signed'({1'b0, peak_q}) - signed'({1'b0, env_q});
		end
	end

	assign tm_prod = tm_a * tm_b;

	// Round the step at 24 fraction bits, add and clamp to 24 bits unsigned
	assign upd_base = (state_q == S_GUPD) ? gain_q : env_q;
	assign upd_rnd  = (prod_q + 51'sd8388608) >>> 24;
	assign upd_sum  = signed'(32'({1'b0, upd_base})) + 32'(upd_rnd);

	always_comb begin
		if (upd_sum < 32'sd0) begin
			upd_val = '0;
		end else if (upd_sum > signed'(32'(alp_pkg::ENV_MAX))) begin
			upd_val = alp_pkg::ENV_MAX;
		end else begin
			upd_val = upd_sum[23:0];
		end
	end

	// AGC divider: target * 2^20 / envelope
	assign div_go = (state_q == S_DIV) && (env_q > alp_pkg::ENV_FLOOR);

	alp_div #(
		.NUM_W(43),
		.DEN_W(24),
		.QUO_W(32)
	) u_agc_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go),
		.num   ({target_q, 20'b0}),
		.den   (env_q),
		.busy  (div_busy),
		.quo   (quo)
	);

	assign mg     = 32'({maxgain_q, 4'b0});
	assign qmin   = (quo > mg) ? mg : quo;
	assign qclamp = (qmin < 32'(alp_pkg::GAIN_FLOOR)) ? 32'(alp_pkg::GAIN_FLOOR) : qmin;

	// Frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			peak_q    <= '0;
			env_q     <= '0;
			gain_q    <= alp_pkg::GAIN_ONE;
			desired_q <= alp_pkg::GAIN_ONE;
			prod_q    <= '0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= s_axis_tlast;
						state_q <= S_FILT;
					end
				end
				S_FILT:  state_q <= mode_q[alp_pkg::MODE_FILT] ? S_FWAIT : S_PEAK;
				S_FWAIT: if (!lanes_busy) state_q <= S_PEAK;
				S_PEAK: begin
					peak_q  <= (pk > 33'(alp_pkg::ENV_MAX)) ? alp_pkg::ENV_MAX : pk[23:0];
					state_q <= S_EMUL;
				end
				S_EMUL: begin
					prod_q  <= tm_prod;
					state_q <= S_EUPD;
				end
				S_EUPD: begin
					env_q   <= upd_val;
					state_q <= mode_q[alp_pkg::MODE_AGC] ? S_DIV : S_CLIP;
				end
				S_DIV: begin
					if (div_go) begin
						state_q <= S_DWAIT;
					end else begin
						desired_q <= alp_pkg::GAIN_ONE;
						state_q   <= S_GMUL;
					end
				end
				S_DWAIT: begin
					if (!div_busy) begin
						desired_q <= qclamp[23:0];
						state_q   <= S_GMUL;
					end
				end
				S_GMUL: begin
					prod_q  <= tm_prod;
					state_q <= S_GUPD;
				end
				S_GUPD: begin
					gain_q  <= upd_val;
					state_q <= S_LGAIN;
				end
				S_LGAIN:  state_q <= S_LGWAIT;
				S_LGWAIT: if (!lanes_busy) state_q <= S_CLIP;
				S_CLIP:   state_q <= S_CWAIT;
				S_CWAIT:  if (!lanes_busy) state_q <= S_DONE;
				S_DONE:   if (out_load) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: load a finished frame, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= 24'(alp_pkg::sat_to(64'(lane_val[0]), alp_pkg::FIELD_W));
			out_right_q <= 24'(alp_pkg::sat_to(64'(lane_val[1]), alp_pkg::FIELD_W));
			out_last_q  <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_right_q, out_left_q};
	assign m_axis_tlast  = out_last_q;

	`ASSERT_NXT(a_out_load, out_load, m_axis_tvalid && (state_q == S_IDLE))
	`ASSERT_IMP(a_lanes_idle, (state_q == S_DONE) || (state_q == S_IDLE), !lanes_busy)
	`ASSERT_IMP(a_div_idle, state_q == S_IDLE, !div_busy)

endmodule
